/* hdl/gbs_pkg.sv */
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    localparam int BOX_W   = 64;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 16;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 2'd1;

    localparam logic [THR_W-1:0] SCORE_THR_RESET   = 16'd16384;
    localparam logic [THR_W-1:0] OVERLAP_THR_RESET = 16'd29491;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_I,
        S_SORT_IW,
        S_SORT_CHK,
        S_SORT_OW,
        S_SORT_SW,
        S_SORT_PUT,
        S_SUP_P,
        S_SUP_PW,
        S_SUP_CUR,
        S_SUP_Q,
        S_SUP_QW,
        S_SUP_QB,
        S_SUP_WAIT,
        S_FLUSH
    } gbs_state_t;

    typedef struct packed {
        logic done;
        logic suppress;
        logic busy;
    } ov_status_t;

endpackage

`default_nettype wire

/* hdl/gbs_ram.sv */
// ----------------------------------------------------------------------------
// gbs_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/gbs_overlap.sv */
// ----------------------------------------------------------------------------
// gbs_overlap
// Multi-cycle overlap test: flags box b when inter/union exceeds threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_overlap (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [gbs_pkg::BOX_W-1:0]   box_a,
    input  wire logic [gbs_pkg::BOX_W-1:0]   box_b,
    input  wire logic [gbs_pkg::THR_W-1:0]   overlap_thr,
    output gbs_pkg::ov_status_t              status
);
    import gbs_pkg::*;

    logic [2:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [BOX_W-1:0] a_reg, b_reg;
    logic [14:0] iw_reg, ih_reg;
    logic [29:0] inter_reg, area_a_reg, area_b_reg;
    logic [30:0] uni_reg;
    logic [46:0] prod_reg;

    logic signed [16:0] al, at, bl, bt, ar, ab, br, bb;
    logic signed [16:0] x1, y1, x2, y2;
    logic signed [17:0] dx, dy;

    always_comb begin
        al = 17'(signed'(a_reg[15:0]));
        at = 17'(signed'(a_reg[31:16]));
        bl = 17'(signed'(b_reg[15:0]));
        bt = 17'(signed'(b_reg[31:16]));
        ar = al + signed'({2'b00, a_reg[46:32]});
        ab = at + signed'({2'b00, a_reg[61:47]});
        br = bl + signed'({2'b00, b_reg[46:32]});
        bb = bt + signed'({2'b00, b_reg[61:47]});
        x1 = (al > bl) ? al : bl;
        y1 = (at > bt) ? at : bt;
        x2 = (ar < br) ? ar : br;
        y2 = (ab < bb) ? ab : bb;
        dx = 18'(x2) - 18'(x1);
        dy = 18'(y2) - 18'(y1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            a_reg <= box_a;
            b_reg <= box_b;
        end
        if (busy_reg) begin
            case (step_reg)
                3'd0: begin
                    iw_reg <= (dx > 18'sd0) ? dx[14:0] : 15'd0;
                    ih_reg <= (dy > 18'sd0) ? dy[14:0] : 15'd0;
                end
                3'd1: inter_reg  <= iw_reg * ih_reg;
                3'd2: area_a_reg <= a_reg[46:32] * a_reg[61:47];
                3'd3: area_b_reg <= b_reg[46:32] * b_reg[61:47];
                3'd4: uni_reg <= 31'(area_a_reg) + 31'(area_b_reg) - 31'(inter_reg);
                3'd5: begin
                    prod_reg <= overlap_thr * uni_reg;
                end
                default: ;
            endcase
        end
    end

    // final compare on the cycle done is raised
    always_comb begin
        status.busy     = busy_reg;
        status.done     = done_reg;
        status.suppress = (uni_reg != 31'd0) && ({1'b0, inter_reg, 16'd0} > prod_reg);
    end

endmodule

`default_nettype wire

/* hdl/greedy_box_suppression_core.sv */
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy non-maximum suppression over one set of up to MAX_BOXES boxes.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_       in   tdata: box_left, box_top, box_width, box_height, confidence
//                tlast: final_box
//  m_       out  tdata: kept_index; tuser: none_kept, dropped_boxes
//                tlast: final_result
//  cfg_     in   index 0 score_threshold, 1 overlap_threshold
//
//  Loading takes one cycle per box. The final box starts a stable insertion
//  sort in the order RAM followed by the suppression pass, which runs box
//  pairs through the shared overlap unit.
//  Inputs are held off during sort and suppression. A held-off output only
//  stalls the pass when the next result must be moved to the output register.
//  Reset is synchronous; RAM contents are not cleared.
`default_nettype none

module greedy_box_suppression_core #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // box_left[15:0] box_top[31:16] box_width[46:32] box_height[61:47]
    // confidence[77:62]
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // kept_index[5:0]
    output logic [7:0]       m_tdata,
    // none_kept[0] dropped_boxes[1]
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic                            cfg_we,
    input  wire logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gbs_pkg::THR_W-1:0]       cfg_wdata
);
    import gbs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BOXES);
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

    gbs_state_t state_reg, state_next;

    logic [THR_W-1:0] score_thr_reg, overlap_thr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next, n_reg, n_next, pos_reg, pos_next;
    logic [CNT_W-1:0] p_reg, p_next, q_reg, q_next;
    logic [SCORE_W-1:0] si_reg, si_next;
    logic [ADDR_W-1:0]  oj_reg, oj_next, cur_reg, cur_next;
    logic [BOX_W-1:0]   box_a_reg, box_a_next;
    logic [MAX_BOXES-1:0] mark_reg, mark_next;
    logic             pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_idx_reg, out_idx_next;
    logic             out_none_reg, out_none_next;
    logic             out_drop_reg, out_drop_next;
    logic             out_last_reg, out_last_next;

    logic              box_we, score_we, order_we;
    logic [ADDR_W-1:0] box_waddr, box_raddr, score_raddr, order_waddr, order_raddr;
    logic [ADDR_W-1:0] order_wdata;
    logic [BOX_W-1:0]  box_rdata;
    logic [SCORE_W-1:0] score_rdata;
    logic [ADDR_W-1:0] order_rdata;
    logic              ov_start;
    ov_status_t        ov_status;

    logic s_fire, out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .aclk (aclk), .we (box_we), .waddr (box_waddr),
        .wdata ({2'b00, s_tdata[61:0]}), .raddr (box_raddr), .rdata (box_rdata)
    );

    gbs_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
        .aclk (aclk), .we (score_we), .waddr (box_waddr),
        .wdata (s_tdata[77:62]), .raddr (score_raddr), .rdata (score_rdata)
    );

    gbs_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BOXES)) u_order_ram (
        .aclk (aclk), .we (order_we), .waddr (order_waddr),
        .wdata (order_wdata), .raddr (order_raddr), .rdata (order_rdata)
    );

    gbs_overlap u_overlap (
        .aclk (aclk), .aresetn (aresetn), .start (ov_start),
        .box_a (box_a_reg), .box_b (box_rdata),
        .overlap_thr (overlap_thr_reg), .status (ov_status)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:     if (s_fire && s_tlast) state_next = S_SORT_I;
            S_SORT_I:   state_next = (i_reg == count_reg) ? S_SUP_P : S_SORT_IW;
            S_SORT_IW:  state_next = (score_rdata > score_thr_reg) ? S_SORT_CHK : S_SORT_I;
            S_SORT_CHK: state_next = (pos_reg == '0) ? S_SORT_PUT : S_SORT_OW;
            S_SORT_OW:  state_next = S_SORT_SW;
            S_SORT_SW:  state_next = (score_rdata < si_reg) ? S_SORT_CHK : S_SORT_PUT;
            S_SORT_PUT: state_next = S_SORT_I;
            S_SUP_P: begin
                if (p_reg == n_reg) begin
                    state_next = S_FLUSH;
                end else if (!mark_reg[p_reg[ADDR_W-1:0]]) begin
                    state_next = S_SUP_PW;
                end
            end
            S_SUP_PW:   state_next = S_SUP_CUR;
            S_SUP_CUR:  if (!pend_reg || out_free) state_next = S_SUP_Q;
            S_SUP_Q: begin
                if (q_reg == n_reg) begin
                    state_next = S_SUP_P;
                end else if (!mark_reg[q_reg[ADDR_W-1:0]]) begin
                    state_next = S_SUP_QW;
                end
            end
            S_SUP_QW:   state_next = S_SUP_QB;
            S_SUP_QB:   state_next = S_SUP_WAIT;
            S_SUP_WAIT: if (ov_status.done) state_next = S_SUP_Q;
            S_FLUSH:    if (out_free) state_next = S_LOAD;
            default:    state_next = S_LOAD;
        endcase
    end

    // memory ports and handshake
    always_comb begin
        s_tready    = (state_reg == S_LOAD);
        box_we      = 1'b0;
        score_we    = 1'b0;
        box_waddr   = count_reg[ADDR_W-1:0];
        order_we    = 1'b0;
        order_waddr = pos_reg[ADDR_W-1:0];
        order_wdata = i_reg[ADDR_W-1:0];
        score_raddr = i_reg[ADDR_W-1:0];
        order_raddr = p_reg[ADDR_W-1:0];
        box_raddr   = cur_reg;
        ov_start    = 1'b0;
        case (state_reg)
            S_LOAD: begin
                box_we   = s_fire && (count_reg < CNT_MAX);
                score_we = s_fire && (count_reg < CNT_MAX);
            end
            S_SORT_CHK: order_raddr = ADDR_W'(pos_reg - CNT_W'(1));
            S_SORT_OW:  score_raddr = order_rdata;
            S_SORT_SW: begin
                order_we    = (score_rdata < si_reg);
                order_wdata = oj_reg;
            end
            S_SORT_PUT: order_we = 1'b1;
            S_SUP_PW:   box_raddr = order_rdata;
            S_SUP_Q:    order_raddr = q_reg[ADDR_W-1:0];
            S_SUP_QW:   box_raddr = order_rdata;
            S_SUP_QB:   ov_start = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        si_next        = si_reg;
        oj_next        = oj_reg;
        cur_next       = cur_reg;
        box_a_next     = box_a_reg;
        mark_next      = mark_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_none_next  = out_none_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            S_LOAD: begin
                i_next = '0;
                n_next = '0;
                p_next = '0;
                if (s_fire) begin
                    if (count_reg < CNT_MAX) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_SORT_IW: begin
                si_next  = score_rdata;
                pos_next = n_reg;
                if (score_rdata <= score_thr_reg) i_next = i_reg + CNT_W'(1);
            end
            S_SORT_OW: oj_next = order_rdata;
            S_SORT_SW: if (score_rdata < si_reg) pos_next = pos_reg - CNT_W'(1);
            S_SORT_PUT: begin
                n_next = n_reg + CNT_W'(1);
                i_next = i_reg + CNT_W'(1);
            end
            S_SUP_P: begin
                if (p_reg != n_reg && mark_reg[p_reg[ADDR_W-1:0]]) begin
                    p_next = p_reg + CNT_W'(1);
                end
            end
            S_SUP_PW: cur_next = order_rdata;
            S_SUP_CUR: begin
                box_a_next = box_rdata;
                if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        out_valid_next = 1'b1;
                        out_idx_next   = pend_idx_reg;
                        out_none_next  = 1'b0;
                        out_drop_next  = ovf_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = cur_reg;
                    q_next        = p_reg + CNT_W'(1);
                end
            end
            S_SUP_Q: begin
                if (q_reg == n_reg) begin
                    p_next = p_reg + CNT_W'(1);
                end else if (mark_reg[q_reg[ADDR_W-1:0]]) begin
                    q_next = q_reg + CNT_W'(1);
                end
            end
            S_SUP_WAIT: begin
                if (ov_status.done) begin
                    if (ov_status.suppress) mark_next[q_reg[ADDR_W-1:0]] = 1'b1;
                    q_next = q_reg + CNT_W'(1);
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = pend_reg ? pend_idx_reg : '0;
                    out_none_next  = !pend_reg;
                    out_drop_next  = ovf_reg;
                    out_last_next  = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    mark_next      = '0;
                    pend_next      = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_LOAD;
            score_thr_reg   <= SCORE_THR_RESET;
            overlap_thr_reg <= OVERLAP_THR_RESET;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            mark_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            mark_reg      <= mark_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCORE_THR:   score_thr_reg   <= cfg_wdata;
                    CFG_OVERLAP_THR: overlap_thr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        si_reg       <= si_next;
        oj_reg       <= oj_next;
        cur_reg      <= cur_next;
        box_a_reg    <= box_a_next;
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_none_reg <= out_none_next;
        out_drop_reg <= out_drop_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 8'(out_idx_reg);
    assign m_tuser  = {out_drop_reg, out_none_reg};
    assign m_tlast  = out_last_reg;

    a_marks_clear_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOAD |-> mark_reg == '0 && !pend_reg)
        else $error("suppression marks left over between sets");

    a_ov_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_status.done |-> state_reg == S_SUP_WAIT)
        else $error("overlap result outside wait state");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
        else $error("empty result not marked last");

    a_no_input_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_LOAD |-> !s_tready && !ov_start || state_reg == S_SUP_QB)
        else $error("input accepted during suppression");

endmodule

`default_nettype wire
